// ===== rtl/core/ptob_pkg.sv =====
// ----------------------------------------------------------------------------
// ptob_pkg
// Types and codes shared by the order book controller, datapath and top.
// ----------------------------------------------------------------------------
package ptob_pkg;

  localparam int unsigned STAMP_W = 48;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned LVL_W   = 9;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_REDUCE = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } ptob_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             best_found;
    logic [31:0]      best_level_price;
    logic [31:0]      front_id;
    logic [31:0]      front_qty;
    logic [SUM_W-1:0] qty_at_price;
    logic [LVL_W-1:0] levels;
  } ptob_out_t;

  // One stored order row
  typedef struct packed {
    logic               side;
    logic [31:0]        ident;
    logic [31:0]        price;
    logic [31:0]        qty;
    logic [STAMP_W-1:0] stamp;
  } ptob_row_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_APPLY,
    S_SCAN_B,
    S_FINISH
  } ptob_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_in;
    logic scan_go;
    logic pass_b;
    logic apply;
    logic load_out;
  } ptob_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic scanning;
  } ptob_sts_t;

endpackage

// ===== rtl/core/price_time_order_book.sv =====
// ----------------------------------------------------------------------------
// price_time_order_book
// Two-sided limit order book with price-time priority over a bounded store.
// ----------------------------------------------------------------------------
//
//   channel  | ports                            | word
//   ---------+----------------------------------+-----------------------------
//   input    | in_valid, in_stall, in_data      | command: add/cancel/reduce/query
//   result   | out_valid, out_stall, out_data   | status, front order, sums, levels
//
// Each command runs one read pass over the order store to match ids and find a
// free row and the front, a write step, a second read pass for the front,
// price sum and level check, and a hand-off step.
// Reset (rst_n low, synchronous) clears valid and indexed flags, the arrival
// stamp and both level counts; the store needs no clearing pass.
// A new command is taken while a result word still waits under out_stall;
// the following result holds in the datapath until the output frees up.
//
module price_time_order_book
  import ptob_pkg::*;
#(
  parameter int unsigned MAX_ORDERS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ptob_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ptob_out_t out_data
);

  ptob_ctl_t ctl;
  ptob_sts_t sts;

  // Sequencer: walks each command through both passes
  ptob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // Store, flags, accumulators and result register
  ptob_dp #(
    .MAX_ORDERS (MAX_ORDERS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .ctl      (ctl),
    .sts      (sts)
  );

endmodule

// ===== rtl/core/ptob_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptob_ctrl
// Sequencer: match pass, apply step, result pass, result hand-off.
// ----------------------------------------------------------------------------
module ptob_ctrl
  import ptob_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ptob_ctl_t ctl,
  input  ptob_sts_t sts
);

  ptob_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_stall  = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.take_in = 1'b1;
          ctl.scan_go = 1'b1;
          state_nxt   = S_SCAN_A;
        end
      end
      S_SCAN_A: begin
        if (sts.scan_done) state_nxt = S_APPLY;
      end
      S_APPLY: begin
        ctl.apply   = 1'b1;
        ctl.scan_go = 1'b1;
        ctl.pass_b  = 1'b1;
        state_nxt   = S_SCAN_B;
      end
      S_SCAN_B: begin
        ctl.pass_b = 1'b1;
        if (sts.scan_done) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        ctl.pass_b = 1'b1;
        if (!out_valid_r || !out_stall) begin
          ctl.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  // Pass end and scan activity stay inside the scan states; a result load returns to idle
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |-> (state_r == S_SCAN_A || state_r == S_SCAN_B))
    else $error("scan end outside a scan state");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.scanning)
    else $error("scan running while idle");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> (state_r == S_IDLE))
    else $error("result load did not return to idle");

endmodule

// ===== rtl/core/ptob_dp.sv =====
// ----------------------------------------------------------------------------
// ptob_dp
// Order store, valid/indexed flags, scan accumulators and result register.
// ----------------------------------------------------------------------------
module ptob_dp
  import ptob_pkg::*;
#(
  parameter int unsigned MAX_ORDERS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ptob_in_t  in_data,
  output ptob_out_t out_data,
  input  ptob_ctl_t ctl,
  output ptob_sts_t sts
);

  localparam int unsigned IW = $clog2(MAX_ORDERS);
  localparam logic [IW-1:0] LAST = IW'(MAX_ORDERS - 1);

  ptob_row_t mem [MAX_ORDERS];

  // Control state
  logic [MAX_ORDERS-1:0] valid_r, valid_nxt;
  logic [MAX_ORDERS-1:0] indexed_r, indexed_nxt;
  logic [STAMP_W-1:0]    counter_r, counter_nxt;
  logic [LVL_W-1:0]      buy_lvl_r, buy_lvl_nxt;
  logic [LVL_W-1:0]      sell_lvl_r, sell_lvl_nxt;
  logic                  scanning_r, scanning_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]         addr_r, addr_nxt;

  // Working registers
  ptob_in_t         cmd_r, cmd_nxt;
  logic [IW-1:0]    rd_idx_r;
  ptob_row_t        rd_row_r;
  logic             free_found_r, free_found_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;
  logic             hit_found_r, hit_found_nxt;
  logic [IW-1:0]    hit_idx_r, hit_idx_nxt;
  ptob_row_t        hit_row_r, hit_row_nxt;
  logic             exist_r, exist_nxt;
  logic             ff_r, ff_nxt;
  logic [IW-1:0]    f_idx_r, f_idx_nxt;
  ptob_row_t        f_row_r, f_row_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             remain_r, remain_nxt;
  logic             chk_en_r, chk_en_nxt;
  logic             rm_side_r, rm_side_nxt;
  logic [31:0]      rm_price_r, rm_price_nxt;
  logic             clr_en_r, clr_en_nxt;
  logic [31:0]      clr_id_r, clr_id_nxt;
  logic             keep_en_r, keep_en_nxt;
  logic [IW-1:0]    keep_idx_r, keep_idx_nxt;
  logic [1:0]       status_r, status_nxt;
  ptob_out_t        out_r, out_nxt;

  logic             mem_we;
  logic [IW-1:0]    mem_waddr;
  ptob_row_t        mem_wdata;

  logic             v_cur;
  logic             better;
  logic [SUM_W:0]   sum_add;
  logic             dec;
  logic [LVL_W-1:0] nb, ns;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_row_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      indexed_r  <= '0;
      counter_r  <= '0;
      buy_lvl_r  <= '0;
      sell_lvl_r <= '0;
      scanning_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      addr_r     <= '0;
    end else begin
      valid_r    <= valid_nxt;
      indexed_r  <= indexed_nxt;
      counter_r  <= counter_nxt;
      buy_lvl_r  <= buy_lvl_nxt;
      sell_lvl_r <= sell_lvl_nxt;
      scanning_r <= scanning_nxt;
      rd_vld_r   <= rd_vld_nxt;
      addr_r     <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    rd_idx_r     <= addr_r;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    hit_found_r  <= hit_found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_row_r    <= hit_row_nxt;
    exist_r      <= exist_nxt;
    ff_r         <= ff_nxt;
    f_idx_r      <= f_idx_nxt;
    f_row_r      <= f_row_nxt;
    sum_r        <= sum_nxt;
    remain_r     <= remain_nxt;
    chk_en_r     <= chk_en_nxt;
    rm_side_r    <= rm_side_nxt;
    rm_price_r   <= rm_price_nxt;
    clr_en_r     <= clr_en_nxt;
    clr_id_r     <= clr_id_nxt;
    keep_en_r    <= keep_en_nxt;
    keep_idx_r   <= keep_idx_nxt;
    status_r     <= status_nxt;
    out_r        <= out_nxt;
  end

  always_comb begin
    valid_nxt      = valid_r;
    indexed_nxt    = indexed_r;
    counter_nxt    = counter_r;
    buy_lvl_nxt    = buy_lvl_r;
    sell_lvl_nxt   = sell_lvl_r;
    scanning_nxt   = scanning_r;
    addr_nxt       = addr_r;
    rd_vld_nxt     = scanning_r;
    cmd_nxt        = cmd_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_row_nxt    = hit_row_r;
    exist_nxt      = exist_r;
    ff_nxt         = ff_r;
    f_idx_nxt      = f_idx_r;
    f_row_nxt      = f_row_r;
    sum_nxt        = sum_r;
    remain_nxt     = remain_r;
    chk_en_nxt     = chk_en_r;
    rm_side_nxt    = rm_side_r;
    rm_price_nxt   = rm_price_r;
    clr_en_nxt     = clr_en_r;
    clr_id_nxt     = clr_id_r;
    keep_en_nxt    = keep_en_r;
    keep_idx_nxt   = keep_idx_r;
    status_nxt     = status_r;
    out_nxt        = out_r;
    mem_we         = 1'b0;
    mem_waddr      = f_idx_r;
    mem_wdata      = f_row_r;
    dec            = 1'b0;
    nb             = buy_lvl_r;
    ns             = sell_lvl_r;

    v_cur   = valid_r[rd_idx_r];
    better  = cmd_r.side ? (rd_row_r.price < f_row_r.price)
                         : (rd_row_r.price > f_row_r.price);
    sum_add = {1'b0, sum_r} + {{(SUM_W - 31){1'b0}}, rd_row_r.qty};

    // Advance the read address through the store
    if (scanning_r) begin
      addr_nxt = addr_r + 1'b1;
      if (addr_r == LAST) scanning_nxt = 1'b0;
    end

    // Process one stored row
    if (rd_vld_r) begin
      if (v_cur && rd_row_r.side == cmd_r.side &&
          (!ff_r || better ||
           (rd_row_r.price == f_row_r.price && rd_row_r.stamp < f_row_r.stamp))) begin
        ff_nxt    = 1'b1;
        f_idx_nxt = rd_idx_r;
        f_row_nxt = rd_row_r;
      end
      if (!ctl.pass_b) begin
        if (!v_cur && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = rd_idx_r;
        end
        if (v_cur && indexed_r[rd_idx_r] && rd_row_r.ident == cmd_r.order_id &&
            !hit_found_r) begin
          hit_found_nxt = 1'b1;
          hit_idx_nxt   = rd_idx_r;
          hit_row_nxt   = rd_row_r;
        end
        if (v_cur && rd_row_r.side == cmd_r.side && rd_row_r.price == cmd_r.price)
          exist_nxt = 1'b1;
      end else begin
        if (v_cur && rd_row_r.side == cmd_r.side && rd_row_r.price == cmd_r.price)
          sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
        if (v_cur && rd_row_r.side == rm_side_r && rd_row_r.price == rm_price_r)
          remain_nxt = 1'b1;
        if (clr_en_r && v_cur && rd_row_r.ident == clr_id_r &&
            !(keep_en_r && rd_idx_r == keep_idx_r))
          indexed_nxt[rd_idx_r] = 1'b0;
      end
    end

    // Start a pass: clear the accumulators
    if (ctl.scan_go) begin
      scanning_nxt   = 1'b1;
      addr_nxt       = '0;
      free_found_nxt = 1'b0;
      hit_found_nxt  = 1'b0;
      exist_nxt      = 1'b0;
      ff_nxt         = 1'b0;
      sum_nxt        = '0;
      remain_nxt     = 1'b0;
    end

    if (ctl.take_in) begin
      cmd_nxt    = in_data;
      chk_en_nxt = 1'b0;
      clr_en_nxt = 1'b0;
      status_nxt = ST_OK;
    end

    // Apply the command between the two passes
    if (ctl.apply) begin
      unique case (cmd_r.cmd)
        CMD_ADD: begin
          if (free_found_r) begin
            mem_we                   = 1'b1;
            mem_waddr                = free_idx_r;
            mem_wdata                = '{side: cmd_r.side, ident: cmd_r.order_id,
                                         price: cmd_r.price, qty: cmd_r.qty,
                                         stamp: counter_r};
            valid_nxt[free_idx_r]    = 1'b1;
            indexed_nxt[free_idx_r]  = 1'b1;
            counter_nxt              = counter_r + 1'b1;
            if (!exist_r) begin
              if (cmd_r.side) sell_lvl_nxt = sell_lvl_r + 1'b1;
              else            buy_lvl_nxt  = buy_lvl_r + 1'b1;
            end
            clr_en_nxt   = 1'b1;
            clr_id_nxt   = cmd_r.order_id;
            keep_en_nxt  = 1'b1;
            keep_idx_nxt = free_idx_r;
          end else begin
            status_nxt = ST_FULL;
          end
        end
        CMD_CANCEL: begin
          if (hit_found_r) begin
            valid_nxt[hit_idx_r]   = 1'b0;
            indexed_nxt[hit_idx_r] = 1'b0;
            chk_en_nxt   = 1'b1;
            rm_side_nxt  = hit_row_r.side;
            rm_price_nxt = hit_row_r.price;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        CMD_REDUCE: begin
          if (!ff_r) begin
            status_nxt = ST_EMPTY;
          end else if (cmd_r.qty >= f_row_r.qty) begin
            valid_nxt[f_idx_r]   = 1'b0;
            indexed_nxt[f_idx_r] = 1'b0;
            chk_en_nxt   = 1'b1;
            rm_side_nxt  = f_row_r.side;
            rm_price_nxt = f_row_r.price;
            clr_en_nxt   = 1'b1;
            clr_id_nxt   = f_row_r.ident;
            keep_en_nxt  = 1'b0;
          end else begin
            mem_we        = 1'b1;
            mem_waddr     = f_idx_r;
            mem_wdata     = f_row_r;
            mem_wdata.qty = f_row_r.qty - cmd_r.qty;
          end
        end
        CMD_QUERY: begin
        end
        default: begin
        end
      endcase
    end

    // Drop a level that lost its last order, then build the result word
    if (ctl.load_out) begin
      dec = chk_en_r && !remain_r;
      if (dec && !rm_side_r) nb = buy_lvl_r - 1'b1;
      if (dec && rm_side_r)  ns = sell_lvl_r - 1'b1;
      buy_lvl_nxt  = nb;
      sell_lvl_nxt = ns;
      out_nxt.status           = status_r;
      out_nxt.best_found       = ff_r;
      out_nxt.best_level_price = ff_r ? f_row_r.price : 32'd0;
      out_nxt.front_id         = ff_r ? f_row_r.ident : 32'd0;
      out_nxt.front_qty        = ff_r ? f_row_r.qty : 32'd0;
      out_nxt.qty_at_price     = sum_r;
      out_nxt.levels           = cmd_r.side ? ns : nb;
    end
  end

  assign sts.scan_done = rd_vld_r && (rd_idx_r == LAST);
  assign sts.scanning  = scanning_r || rd_vld_r;
  assign out_data      = out_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !scanning_r && !rd_vld_r)
    else $error("store written during a scan");
  a_read_follows_addr: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(scanning_r))
    else $error("read data without an issued address");
  a_take_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.take_in |-> !scanning_r && !rd_vld_r)
    else $error("new command while a scan runs");
  a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.apply && cmd_r.cmd == CMD_ADD && free_found_r) |=>
      counter_r == $past(counter_r) + 1'b1)
    else $error("arrival stamp did not advance on add");

endmodule
